@@ hdl/rblt_pkg.sv @@
// ----------------------------------------------------------------------------
// rblt_pkg: shared types and constants for the range block list table
// Request and response payloads, operation codes, cell control and cell state.
// ----------------------------------------------------------------------------
package rblt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ID_WIDTH    = 32;
  localparam int ADDR_WIDTH  = 3;

  // Register indexes on the configuration port
  localparam logic REG_USE_CONTOUR = 1'b0;
  localparam logic REG_USE_SYMBOL  = 1'b1;

  typedef logic [ID_WIDTH-1:0]    id_t;
  typedef logic [MAX_ENTRIES-1:0] flag_vec_t;

  localparam flag_vec_t ONE_VEC = flag_vec_t'(1);

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] station_id;
    logic [31:0] range_end;
    logic        entry_enabled;
    logic        symbol_case;
  } req_t;

  typedef struct packed {
    logic blocked;
    logic status;
  } rsp_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic  accept;
    func_t func;
    logic  shift_en;
  } cell_ctl_t;

  // What one cell shows its neighbor
  typedef struct packed {
    logic valid;
    logic flag;
    logic on;
    id_t  start_id;
    id_t  end_id;
  } cell_state_t;

  typedef struct packed {
    logic      any;
    logic      blocked;
    flag_vec_t shift_mask;
  } resolve_t;

  // Take an id in its low ID_WIDTH bits
  function automatic id_t to_id(input logic [31:0] v);
    logic [63:0] w;
    w = {32'b0, v};
    return w[ID_WIDTH-1:0];
  endfunction

endpackage

@@ hdl/range_block_list_table.sv @@
// ----------------------------------------------------------------------------
// range_block_list_table: first-match range block list for station ids
// Ordered table of id ranges held in a row of cells, with lookup, add,
// remove-by-start-id and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the request is taken at a
//   clock edge with start high and busy low. func selects lookup, add,
//   remove or clear.
//   Result channel: exactly one result per request, shown on rsp for one
//   cycle with done high. The receiver cannot stall; sample it on done.
//   Timing: the accept edge latches every cell's compare into its flag bit;
//   the next edge resolves the first match and registers the result, so done
//   is high in the cycle after that edge for lookup, add and clear. Busy is
//   low again in the done cycle, so no new request is taken before the last
//   one is answered. Remove adds a shift step per deleted entry, since each
//   step shifts the cells above the lowest flagged cell down by one place.
//   Configuration: APB registers use_with_contour (0x0) and use_with_symbol
//   (0x4), bit 0 only; write them only while the block is idle.
//   Reset: synchronous, clears all valid bits (empty table), both enables and
//   the control state. Entry contents are left as they are.
// ----------------------------------------------------------------------------
module range_block_list_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  rblt_pkg::req_t                      req,
  output logic                                done,
  output rblt_pkg::rsp_t                      rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rblt_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import rblt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_t;

  state_t      state;
  func_t       op;
  logic        active;
  logic        full_hit;
  logic        use_with_contour;
  logic        use_with_symbol;

  logic        accept;
  logic        remove_step;
  logic        cfg_wr;
  cell_ctl_t   ctl;
  resolve_t    res;
  cell_state_t cs [MAX_ENTRIES];
  flag_vec_t   flags;
  flag_vec_t   ons;
  flag_vec_t   valid_vec;
  flag_vec_t   valid_inc;

  // --------------------------------------------------------------------------
  // Configuration port: register index is the word address bit
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_with_contour <= 1'b0;
      use_with_symbol  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_USE_CONTOUR: use_with_contour <= pwdata[0];
        REG_USE_SYMBOL:  use_with_symbol  <= pwdata[0];
        default:         use_with_contour <= use_with_contour;
      endcase
    end
  end

  assign prdata = {31'b0, (paddr[2] == REG_USE_SYMBOL) ? use_with_symbol : use_with_contour};

  // --------------------------------------------------------------------------
  // Cell row: the accept edge applies add/clear and latches compare flags,
  // remove steps shift cells down toward index 0
  // --------------------------------------------------------------------------
  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign remove_step = (state == S_FINISH) && (op == FUNC_REMOVE) && res.any;

  assign ctl = '{accept: accept, func: req.func, shift_en: remove_step};

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cell_state_t nb;
    logic        prev_valid;

    if (i == MAX_ENTRIES - 1) begin : g_top
      assign nb = '0;
    end else begin : g_mid
      assign nb = cs[i+1];
    end

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = cs[i-1].valid;
    end

    rblt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .req        (req),
      .prev_valid (prev_valid),
      .shift      (res.shift_mask[i]),
      .nb         (nb),
      .st         (cs[i])
    );

    assign flags[i]     = cs[i].flag;
    assign ons[i]       = cs[i].on;
    assign valid_vec[i] = cs[i].valid;
  end

  rblt_resolve u_resolve (
    .flags (flags),
    .ons   (ons),
    .res   (res)
  );

  assign valid_inc = valid_vec + ONE_VEC;

  // --------------------------------------------------------------------------
  // Sequencer: hold the request's op, step removes, register the result
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= req.func;
            active   <= req.symbol_case ? use_with_symbol : use_with_contour;
            // table is full when the last cell already holds an entry
            full_hit <= cs[MAX_ENTRIES-1].valid;
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          // keep shifting while flagged entries remain
          if (!remove_step) begin
            done        <= 1'b1;
            rsp.blocked <= (op == FUNC_LOOKUP) && active && res.blocked;
            rsp.status  <= (op == FUNC_ADD) && full_hit;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("block not busy after taking a request");

  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_inc & valid_vec) == '0)
    else $error("valid entries not packed from index 0");

  a_rsp_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.blocked && rsp.status))
    else $error("blocked and full reported together");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

endmodule

@@ hdl/rblt_cell.sv @@
// ----------------------------------------------------------------------------
// rblt_cell: one entry of the block list
// Holds start id, end id and enabled flag; compares against the request and
// shifts down from its upper neighbor while entries are removed.
// ----------------------------------------------------------------------------
module rblt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  rblt_pkg::cell_ctl_t  ctl,
  input  rblt_pkg::req_t       req,
  input  logic                 prev_valid,
  input  logic                 shift,
  input  rblt_pkg::cell_state_t nb,
  output rblt_pkg::cell_state_t st
);
  import rblt_pkg::*;

  logic valid;
  logic flag;
  logic on;
  id_t  start_id;
  id_t  end_id;

  id_t  req_id;
  logic hit;
  logic eq;
  logic take_add;
  logic do_shift;

  assign req_id   = to_id(req.station_id);
  assign eq       = (req_id == start_id);
  assign hit      = (start_id < end_id) ? (req_id >= start_id && req_id <= end_id) : eq;
  assign take_add = ctl.accept && (ctl.func == FUNC_ADD) && !valid && prev_valid;
  assign do_shift = ctl.shift_en && shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      flag  <= 1'b0;
    end else if (ctl.accept) begin
      case (ctl.func)
        FUNC_CLEAR: valid <= 1'b0;
        FUNC_ADD:   if (take_add) valid <= 1'b1;
        default:    valid <= valid;
      endcase
      flag <= valid && ((ctl.func == FUNC_REMOVE) ? eq : hit);
    end else if (do_shift) begin
      valid <= nb.valid;
      flag  <= nb.flag;
    end
  end

  always_ff @(posedge clk) begin
    if (take_add) begin
      start_id <= req_id;
      end_id   <= to_id(req.range_end);
      on       <= req.entry_enabled;
    end else if (do_shift) begin
      start_id <= nb.start_id;
      end_id   <= nb.end_id;
      on       <= nb.on;
    end
  end

  assign st = '{valid: valid, flag: flag, on: on, start_id: start_id, end_id: end_id};

endmodule

@@ hdl/rblt_resolve.sv @@
// ----------------------------------------------------------------------------
// rblt_resolve: first-match resolution across the cell row
// Isolate the lowest flagged cell, give its enabled bit and the mask of cells
// at or above it.
// ----------------------------------------------------------------------------
module rblt_resolve (
  input  rblt_pkg::flag_vec_t flags,
  input  rblt_pkg::flag_vec_t ons,
  output rblt_pkg::resolve_t  res
);
  import rblt_pkg::*;

  flag_vec_t lowest;

  assign lowest         = flags & (~flags + ONE_VEC);
  assign res.any        = |flags;
  assign res.blocked    = |(lowest & ons);
  assign res.shift_mask = ~(lowest - ONE_VEC);

endmodule

@@ dv/rblt_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rblt_check_pkg: result checker for the range block list table
// Tracks the ordered entry table and both enables, predicts the answer of
// every accepted request and compares it with the result the block returns.
// ----------------------------------------------------------------------------
package rblt_check_pkg;
  import rblt_pkg::*;

  class block_list_checker;
    id_t         ent_start [MAX_ENTRIES];
    id_t         ent_end   [MAX_ENTRIES];
    logic        ent_on    [MAX_ENTRIES];
    int unsigned ent_count;
    logic        contour_en;
    logic        symbol_en;
    rsp_t        expected_q[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned n_lookup, n_blocked, n_add, n_full, n_remove, n_dropped, n_clear;

    function new();
      ent_count  = 0;
      contour_en = 1'b0;
      symbol_en  = 1'b0;
      mismatches = 0;
      results_seen = 0;
      n_lookup = 0; n_blocked = 0; n_add = 0; n_full = 0;
      n_remove = 0; n_dropped = 0; n_clear = 0;
    endfunction

    function void set_reg(input logic idx, input logic [31:0] value);
      if (idx == REG_USE_CONTOUR) contour_en = value[0];
      else symbol_en = value[0];
    endfunction

    // First entry in insertion order that covers the id decides
    function logic first_match_flag(input id_t id);
      logic hit;
      for (int i = 0; i < ent_count; i++) begin
        if (ent_start[i] < ent_end[i]) hit = (id >= ent_start[i]) && (id <= ent_end[i]);
        else hit = (id == ent_start[i]);
        if (hit) return ent_on[i];
      end
      return 1'b0;
    endfunction

    function void note_request(input req_t r);
      rsp_t        answer;
      int unsigned keep;
      answer = '0;
      case (r.func)
        FUNC_LOOKUP: begin
          n_lookup++;
          if (r.symbol_case ? symbol_en : contour_en)
            answer.blocked = first_match_flag(id_t'(r.station_id));
          if (answer.blocked) n_blocked++;
        end
        FUNC_ADD: begin
          n_add++;
          if (ent_count < MAX_ENTRIES) begin
            ent_start[ent_count] = id_t'(r.station_id);
            ent_end[ent_count]   = id_t'(r.range_end);
            ent_on[ent_count]    = r.entry_enabled;
            ent_count++;
          end else begin
            answer.status = 1'b1;
            n_full++;
          end
        end
        FUNC_REMOVE: begin
          n_remove++;
          keep = 0;
          for (int i = 0; i < ent_count; i++) begin
            if (ent_start[i] != id_t'(r.station_id)) begin
              ent_start[keep] = ent_start[i];
              ent_end[keep]   = ent_end[i];
              ent_on[keep]    = ent_on[i];
              keep++;
            end
          end
          n_dropped += ent_count - keep;
          ent_count = keep;
        end
        FUNC_CLEAR: begin
          n_clear++;
          ent_count = 0;
        end
        default: ;
      endcase
      // append at the tail, results come back in request order
      expected_q = {expected_q, answer};
    endfunction

    function void report(input string what, input logic want, input logic got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t result %0d: %s expected %0b, got %0b", $time, results_seen, what,
                 want, got);
    endfunction

    function void check_result(input rsp_t got);
      rsp_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t result %0d arrived with no request waiting (blocked %0b status %0b)",
                   $time, results_seen, got.blocked, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.blocked !== want.blocked) report("blocked", want.blocked, got.blocked);
      if (got.status !== want.status) report("status", want.status, got.status);
    endfunction
  endclass

endpackage

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for range_block_list_table
// Drives lookup, add, remove and clear requests through the start/busy
// handshake, moves both enables over the APB port between phases, and checks
// every result strobe against a predicted answer in request order.
// ----------------------------------------------------------------------------
module tb;
  import rblt_pkg::*;
  import rblt_check_pkg::*;

  localparam int PHASE_ITEMS = 170;   // five random phases
  localparam int STALL_LIMIT = 1000;  // worst legal quiet stretch is a 64-entry remove

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  req_t                  req = '0;
  logic                  done;
  rsp_t                  rsp;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  block_list_checker chk;
  int unsigned       quiet_cycles = 0;
  bit                gap_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  range_block_list_table u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Results cannot be held off: take every strobe at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) chk.check_result(rsp);
  end

  // Watchdog: any request, result or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present a request and hold it until the block takes it. Start stays
  // high on return so back-to-back requests need not drop and raise it again.
  task automatic send_request(input req_t r);
    req   <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    chk.note_request(r);
  endtask

  // Drop start for a random idle gap.
  task automatic idle_gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 5)) @(posedge clk);
  endtask

  // Drop start and wait until every outstanding request has answered.
  task automatic drain();
    start <= 1'b0;
    while (chk.expected_q.size() != 0) @(posedge clk);
  endtask

  // Setup then access cycle; psel is left high so writes can chain.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    chk.set_reg(idx, value);
  endtask

  // Write both enables with random upper bits, then release the bus.
  task automatic set_enables(input logic contour, input logic symbol);
    write_reg(REG_USE_CONTOUR, ($urandom() & 32'hFFFF_FFFE) | contour);
    write_reg(REG_USE_SYMBOL, ($urandom() & 32'hFFFF_FFFE) | symbol);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic req_t mk(input func_t f, input id_t id, input id_t last, input logic on,
                              input logic sym);
    req_t r;
    r.func          = f;
    r.station_id    = id;
    r.range_end     = last;
    r.entry_enabled = on;
    r.symbol_case   = sym;
    return r;
  endfunction

  // Half the time ids that sit on or next to a range edge already in the table,
  // plus a small pool that makes duplicate starts, the top of the id space
  // and fully random ids.
  function automatic id_t pick_id();
    int unsigned k;
    id_t         base;
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2, 3: return $urandom_range(0, 15);
      4:    return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: begin
        if (chk.ent_count == 0) return $urandom_range(0, 15);
        k    = $urandom_range(0, chk.ent_count - 1);
        base = $urandom_range(0, 1) ? chk.ent_start[k] : chk.ent_end[k];
        return base + id_t'($urandom_range(0, 2)) - id_t'(1);
      end
    endcase
  endfunction

  // Fill mode leans on adds so the table hits its limit; otherwise lookups
  // dominate. Fields an operation ignores still carry random values.
  function automatic req_t random_request(input bit fill);
    req_t        r;
    int unsigned roll;
    int unsigned k;
    r = mk(FUNC_LOOKUP, pick_id(), $urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (fill) roll = (roll < 70) ? 60 : (roll < 92) ? 0 : (roll < 98) ? 92 : 99;
    if (roll < 55) begin
      r.func = FUNC_LOOKUP;
    end else if (roll < 85) begin
      r.func = FUNC_ADD;
      case ($urandom_range(0, 4))
        0, 1: r.range_end = r.station_id + $urandom_range(0, 40);
        2:    r.range_end = r.station_id;
        3:    r.range_end = r.station_id - $urandom_range(1, 40);
        default: ;
      endcase
    end else if (roll < 97) begin
      r.func = FUNC_REMOVE;
      if (chk.ent_count != 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, chk.ent_count - 1);
        r.station_id = chk.ent_start[k];
      end
    end else begin
      r.func = FUNC_CLEAR;
    end
    return r;
  endfunction

  initial begin
    req_t       directed[$];
    logic [1:0] enables[5];
    bit         fill_mode[5];
    chk = new();
    enables   = '{2'b11, 2'b01, 2'b10, 2'b00, 2'b11};
    fill_mode = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lookup on an empty table with both enables still at their reset value
    send_request(mk(FUNC_LOOKUP, '0, $urandom(), 1'b1, 1'b0));
    drain();
    set_enables(1'b1, 1'b1);

    // Ranges, single ids, a reversed pair, the extremes, shadowing by order,
    // remove with several and with no matching entries, then clear.
    directed = '{
      mk(FUNC_ADD,    32'd10,          32'd20,          1'b1, 1'b0),
      mk(FUNC_ADD,    32'd15,          32'd15,          1'b0, 1'b1),
      mk(FUNC_ADD,    32'd30,          32'd25,          1'b1, 1'b0),
      mk(FUNC_ADD,    32'hFFFF_FFFF,   32'd0,           1'b1, 1'b1),
      mk(FUNC_ADD,    32'd10,          32'd10,          1'b0, 1'b0),
      mk(FUNC_LOOKUP, 32'd10,          32'hFFFF_FFFF,   1'b0, 1'b0),
      mk(FUNC_LOOKUP, 32'd20,          32'd0,           1'b1, 1'b1),
      mk(FUNC_LOOKUP, 32'd21,          32'd0,           1'b0, 1'b0),
      mk(FUNC_LOOKUP, 32'd25,          32'd0,           1'b0, 1'b1),
      mk(FUNC_LOOKUP, 32'd30,          32'd0,           1'b0, 1'b0),
      mk(FUNC_LOOKUP, 32'hFFFF_FFFF,   32'd0,           1'b0, 1'b1),
      mk(FUNC_REMOVE, 32'd10,          32'hFFFF_FFFF,   1'b1, 1'b1),
      mk(FUNC_LOOKUP, 32'd15,          32'd0,           1'b0, 1'b0),
      mk(FUNC_REMOVE, 32'd12345,       32'd0,           1'b0, 1'b0),
      mk(FUNC_ADD,    32'd0,           32'hFFFF_FFFF,   1'b0, 1'b0),
      mk(FUNC_LOOKUP, 32'd0,           32'd0,           1'b0, 1'b1),
      mk(FUNC_LOOKUP, 32'h8000_0000,   32'd0,           1'b0, 1'b0),
      mk(FUNC_REMOVE, 32'd15,          32'd0,           1'b0, 1'b0),
      mk(FUNC_CLEAR,  32'hFFFF_FFFF,   32'hFFFF_FFFF,   1'b1, 1'b1),
      mk(FUNC_LOOKUP, 32'd30,          32'd0,           1'b0, 1'b0)
    };
    foreach (directed[i]) begin
      if ($urandom_range(0, 2) == 0) idle_gap();
      send_request(directed[i]);
    end

    // Random phases, one enable setting each; the last runs with no gaps.
    for (int p = 0; p < 5; p++) begin
      drain();
      set_enables(enables[p][1], enables[p][0]);
      gap_on = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 25 == 0) gap_on = (p != 4) && ($urandom_range(0, 2) != 0);
        if (gap_on && $urandom_range(0, 3) == 0) idle_gap();
        send_request(random_request(fill_mode[p]));
      end
    end

    drain();
    repeat (4) @(posedge clk);

    $display("%0d lookups (%0d blocked), %0d adds (%0d refused on a full table)",
             chk.n_lookup, chk.n_blocked, chk.n_add, chk.n_full);
    $display("%0d removes dropping %0d entries, %0d clears, all four enable settings",
             chk.n_remove, chk.n_dropped, chk.n_clear);
    if (chk.mismatches == 0 && chk.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", chk.mismatches, chk.expected_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rblt_pkg.sv
hdl/rblt_cell.sv
hdl/rblt_resolve.sv
hdl/range_block_list_table.sv
dv/rblt_check_pkg.sv
dv/tb.sv
